### sv/hsvrgb_pkg.sv
// hsvrgb_pkg: widths, arithmetic constants, sector codes and pipeline control
// types shared by the HSV to RGB converter. No dependencies.
package hsvrgb_pkg;

	localparam int COMPONENT_BITS = 8;
	localparam int HUE_FRAC_BITS  = 6;
	localparam int HUE_W          = 16;

	// component scale: all ones means 1.0
	localparam int COMP_MAX  = (2 ** COMPONENT_BITS) - 1;
	localparam int HALF_COMP = COMP_MAX / 2;
	localparam int PROD_W    = 2 * COMPONENT_BITS;

	// hue geometry
	localparam int SECT_DEG = 60;
	localparam int NUM_SECT = 6;
	localparam int SECT     = SECT_DEG * (2 ** HUE_FRAC_BITS);
	localparam int HUE_FULL = NUM_SECT * SECT;
	localparam int HUE_CW   = $clog2(HUE_FULL + 1);
	localparam int CMP_W    = (HUE_W > HUE_CW) ? HUE_W : HUE_CW;
	localparam int SEC_W    = $clog2(NUM_SECT + 1);
	localparam int FRAC_W   = $clog2(SECT + 1);

	// secondary component: round(C * f / SECT), SECT = SECT_DEG << HUE_FRAC_BITS
	localparam int XM_W     = COMPONENT_BITS + FRAC_W;
	localparam int XN_W     = XM_W - HUE_FRAC_BITS;
	localparam int RECIP_SH = XN_W + 6;
	localparam longint RECIP_L = (64'd1 << RECIP_SH) / SECT_DEG;
	localparam int RECIP_W  = $clog2(RECIP_L + 1);
	localparam int XP_W     = XN_W + RECIP_W;

	// sectors of the hexcone, named by the hue span they cover
	localparam logic [SEC_W-1:0] SEC_RED_YEL = SEC_W'(0);
	localparam logic [SEC_W-1:0] SEC_YEL_GRN = SEC_W'(1);
	localparam logic [SEC_W-1:0] SEC_GRN_CYN = SEC_W'(2);
	localparam logic [SEC_W-1:0] SEC_CYN_BLU = SEC_W'(3);
	localparam logic [SEC_W-1:0] SEC_BLU_MAG = SEC_W'(4);

	localparam int NUM_STAGES = 6;

	typedef struct packed {
		logic [NUM_STAGES-1:0] ld;
		logic                  in_stall;
		logic                  out_valid;
	} pipe_ctrl_t;

endpackage

### sv/hsvrgb_pipe_ctrl.sv
// hsvrgb_pipe_ctrl: valid bits and per-stage load enables for the converter
// pipeline, with bubble squeeze under output stall. Uses hsvrgb_pkg.
module hsvrgb_pipe_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    out_stall,
	output hsvrgb_pkg::pipe_ctrl_t  ctrl
);
	import hsvrgb_pkg::*;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] en;
	logic [NUM_STAGES-1:0] up;

	// a stage may load when it is empty or its content moves on
	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || !out_stall;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign up = {vld_q[NUM_STAGES-2:0], in_valid};

	assign ctrl.ld        = en & up;
	assign ctrl.in_stall  = !en[0];
	assign ctrl.out_valid = vld_q[NUM_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (en & up) | (~en & vld_q);
		end
	end

endmodule

### sv/hsv_to_rgb_converter.sv
// hsv_to_rgb_converter: six-stage pipelined HSV to RGB conversion.
// Depends on hsvrgb_pkg and hsvrgb_pipe_ctrl.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: hue in 1/64
//   degree (clamped to 360 degrees), saturation and brightness as 8-bit
//   fractions. Output channel (out_valid / out_stall) returns red, green
//   and blue as 8-bit fractions, one result per request, in order.
//   Throughput is one request per cycle while the output is not stalled:
//   the six register stages are set by the two multiply-then-divide steps
//   (by 255 for the chroma, by 3840 for the secondary component).
//   When out_stall is high the output register holds; upstream stages keep
//   loading until they fill, so bubbles squeeze out, and in_stall rises only
//   once all six stages hold data. Nothing is lost or repeated.
//   Reset (arst_n low) clears all valid bits at once; data registers are
//   not reset. The block keeps no state between requests.
//
// Stages: 1 clamp hue, split sector/remainder, V*S
//         2 chroma = round(V*S/255), fold remainder for odd sectors
//         3 C*f + rounding
//         4 reciprocal multiply for /60 (after /64 shift)
//         5 quotient correction -> X
//         6 place C, X, 0 by sector, add V-C
module hsv_to_rgb_converter (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [hsvrgb_pkg::HUE_W-1:0]            hue,
	input  logic [hsvrgb_pkg::COMPONENT_BITS-1:0]   saturation,
	input  logic [hsvrgb_pkg::COMPONENT_BITS-1:0]   brightness,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [hsvrgb_pkg::COMPONENT_BITS-1:0]   red,
	output logic [hsvrgb_pkg::COMPONENT_BITS-1:0]   green,
	output logic [hsvrgb_pkg::COMPONENT_BITS-1:0]   blue
);
	import hsvrgb_pkg::*;

	localparam int CB = COMPONENT_BITS;

	pipe_ctrl_t ctrl;

	hsvrgb_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.ctrl      (ctrl)
	);

	assign in_stall  = ctrl.in_stall;
	assign out_valid = ctrl.out_valid;

	// ---------------- stage 1: clamp, sector split, V*S ----------------
	logic [CMP_W-1:0]  hue_x;
	logic [HUE_CW-1:0] hue_c;
	logic [HUE_CW-1:0] base;
	logic [SEC_W-1:0]  sec;
	logic [FRAC_W-1:0] frac;
	logic [PROD_W-1:0] vs;

	always_comb begin
		hue_x = CMP_W'(hue);
		if (hue_x > CMP_W'(HUE_FULL)) begin
			hue_c = HUE_CW'(HUE_FULL);
		end else begin
			hue_c = HUE_CW'(hue_x);
		end
		// independent threshold compares; the highest one passed wins
		sec  = '0;
		base = '0;
		for (int k = 1; k <= NUM_SECT; k++) begin
			if (hue_c >= HUE_CW'(k * SECT)) begin
				sec  = SEC_W'(k);
				base = HUE_CW'(k * SECT);
			end
		end
		frac = FRAC_W'(hue_c - base);
		vs   = PROD_W'(saturation) * PROD_W'(brightness);
	end

	logic [SEC_W-1:0]  sector_s1;
	logic [FRAC_W-1:0] frac_s1;
	logic [PROD_W-1:0] vs_s1;
	logic [CB-1:0]     val_s1;

	always_ff @(posedge clk) begin
		if (ctrl.ld[0]) begin
			sector_s1 <= sec;
			frac_s1   <= frac;
			vs_s1     <= vs;
			val_s1    <= brightness;
		end
	end

	// ---------------- stage 2: chroma and folded remainder ----------------
	// n / (2^CB - 1): take q0 = n >> CB, remainder r = low bits + q0 lies
	// below 2*MAXC + 2, so at most two corrections
	logic [PROD_W-1:0] n1;
	logic [CB-1:0]     q1;
	logic [CB:0]       r1;
	logic [CB-1:0]     chroma;
	logic [FRAC_W-1:0] fsel;

	always_comb begin
		n1     = vs_s1 + PROD_W'(HALF_COMP);
		q1     = n1[PROD_W-1:CB];
		r1     = {1'b0, n1[CB-1:0]} + {1'b0, q1};
		chroma = q1 + CB'(r1 >= (CB+1)'(COMP_MAX)) + CB'(r1 >= (CB+1)'(2 * COMP_MAX));
		fsel   = sector_s1[0] ? (FRAC_W'(SECT) - frac_s1) : frac_s1;
	end

	logic [SEC_W-1:0]  sector_s2;
	logic [FRAC_W-1:0] f_s2;
	logic [CB-1:0]     chroma_s2;
	logic [CB-1:0]     val_s2;

	always_ff @(posedge clk) begin
		if (ctrl.ld[1]) begin
			sector_s2 <= sector_s1;
			f_s2      <= fsel;
			chroma_s2 <= chroma;
			val_s2    <= val_s1;
		end
	end

	// ---------------- stage 3: C*f with rounding bias ----------------
	logic [XM_W-1:0] xm;

	assign xm = XM_W'(chroma_s2) * XM_W'(f_s2) + XM_W'(SECT / 2);

	logic [SEC_W-1:0] sector_s3;
	logic [XM_W-1:0]  xm_s3;
	logic [CB-1:0]    chroma_s3;
	logic [CB-1:0]    val_s3;

	always_ff @(posedge clk) begin
		if (ctrl.ld[2]) begin
			sector_s3 <= sector_s2;
			xm_s3     <= xm;
			chroma_s3 <= chroma_s2;
			val_s3    <= val_s2;
		end
	end

	// ---------------- stage 4: /64 shift, reciprocal multiply for /60 ----------
	logic [XN_W-1:0] xn;
	logic [XP_W-1:0] xp;

	always_comb begin
		xn = xm_s3[XM_W-1:HUE_FRAC_BITS];
		xp = XP_W'(xn) * XP_W'(RECIP_L);
	end

	logic [SEC_W-1:0] sector_s4;
	logic [XN_W-1:0]  xn_s4;
	logic [CB-1:0]    q_s4;
	logic [CB-1:0]    chroma_s4;
	logic [CB-1:0]    val_s4;

	always_ff @(posedge clk) begin
		if (ctrl.ld[3]) begin
			sector_s4 <= sector_s3;
			xn_s4     <= xn;
			q_s4      <= xp[RECIP_SH +: CB];
			chroma_s4 <= chroma_s3;
			val_s4    <= val_s3;
		end
	end

	// ---------------- stage 5: quotient correction ----------------
	// the truncated reciprocal undershoots by at most one
	logic [XN_W-1:0] r5;
	logic [CB-1:0]   xval;

	always_comb begin
		r5   = xn_s4 - XN_W'(q_s4) * XN_W'(SECT_DEG);
		xval = q_s4 + CB'(r5 >= XN_W'(SECT_DEG));
	end

	logic [SEC_W-1:0] sector_s5;
	logic [CB-1:0]    x_s5;
	logic [CB-1:0]    chroma_s5;
	logic [CB-1:0]    val_s5;

	always_ff @(posedge clk) begin
		if (ctrl.ld[4]) begin
			sector_s5 <= sector_s4;
			x_s5      <= xval;
			chroma_s5 <= chroma_s4;
			val_s5    <= val_s4;
		end
	end

	// ---------------- stage 6: placement and offset ----------------
	logic [CB-1:0] offset;
	logic [CB-1:0] rc;
	logic [CB-1:0] gc;
	logic [CB-1:0] bc;

	always_comb begin
		offset = val_s5 - chroma_s5;
		unique case (sector_s5)
			SEC_RED_YEL: begin
				rc = chroma_s5; gc = x_s5;      bc = '0;
			end
			SEC_YEL_GRN: begin
				rc = x_s5;      gc = chroma_s5; bc = '0;
			end
			SEC_GRN_CYN: begin
				rc = '0;        gc = chroma_s5; bc = x_s5;
			end
			SEC_CYN_BLU: begin
				rc = '0;        gc = x_s5;      bc = chroma_s5;
			end
			SEC_BLU_MAG: begin
				rc = x_s5;      gc = '0;        bc = chroma_s5;
			end
			// magenta-to-red sector, and hue of exactly 360 degrees
			default: begin
				rc = chroma_s5; gc = '0;        bc = x_s5;
			end
		endcase
	end

	logic [CB-1:0] red_s6;
	logic [CB-1:0] green_s6;
	logic [CB-1:0] blue_s6;

	always_ff @(posedge clk) begin
		if (ctrl.ld[5]) begin
			red_s6   <= rc + offset;
			green_s6 <= gc + offset;
			blue_s6  <= bc + offset;
		end
	end

	assign red   = red_s6;
	assign green = green_s6;
	assign blue  = blue_s6;

endmodule

### sv/hsvrgb_checker.sv
// hsvrgb_checker: port-level assertions for hsv_to_rgb_converter, bound to
// the top level below. Uses hsvrgb_pkg for field widths.
module hsvrgb_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_stall,
	input logic [hsvrgb_pkg::HUE_W-1:0]            hue,
	input logic [hsvrgb_pkg::COMPONENT_BITS-1:0]   saturation,
	input logic [hsvrgb_pkg::COMPONENT_BITS-1:0]   brightness,
	input logic                                    out_valid,
	input logic                                    out_stall,
	input logic [hsvrgb_pkg::COMPONENT_BITS-1:0]   red,
	input logic [hsvrgb_pkg::COMPONENT_BITS-1:0]   green,
	input logic [hsvrgb_pkg::COMPONENT_BITS-1:0]   blue
);
	import hsvrgb_pkg::*;

	// reset empties the pipeline; valid bits clear as soon as arst_n falls
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("out_valid high during reset");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red) && $stable(green)
		&& $stable(blue))
		else $error("stalled result changed");

	// input is held back only when every stage is full behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall without a stalled output");

	// a request accepted while the output runs free must reach out_valid
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
		##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("result missing after six cycles");

	// zero saturation gives gray at the input brightness
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && saturation == '0 ##1 !out_stall ##1 !out_stall
		##1 !out_stall ##1 !out_stall ##1 !out_stall
		|=> red == $past(brightness, 6) && green == $past(brightness, 6)
		&& blue == $past(brightness, 6))
		else $error("gray request gave a colored result");

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (.*);

### dv/tb.sv
// tb: self-checking testbench for hsv_to_rgb_converter, with a queue-fed driver,
// a checking monitor and an in-line HSV to RGB predictor.
// Depends on hsvrgb_pkg and the hsv_to_rgb_converter RTL.
`timescale 1ns / 100ps

module tb;
	import hsvrgb_pkg::*;

	// Run control: the run stops here if the DUT hangs.
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PIPE_LATENCY  = 6;
	localparam int RANDOM_REQS   = 700;
	localparam int BLOCK_REQS    = 50;
	localparam int LONG_HOLD     = 100;
	localparam int LONG_HOLD_AT  = 200;
	localparam int MAX_PRINTED   = 40;

	typedef struct {
		logic [HUE_W-1:0]          hue;
		logic [COMPONENT_BITS-1:0] sat;
		logic [COMPONENT_BITS-1:0] val;
		int unsigned               gap;
		bit                        drain;
	} hsv_req_t;

	typedef struct {
		logic [COMPONENT_BITS-1:0] red;
		logic [COMPONENT_BITS-1:0] green;
		logic [COMPONENT_BITS-1:0] blue;
	} rgb_t;

	logic                      clk;
	logic                      arst_n     = 1'b0;
	logic                      in_valid   = 1'b0;
	logic                      in_stall;
	logic [HUE_W-1:0]          hue        = '0;
	logic [COMPONENT_BITS-1:0] saturation = '0;
	logic [COMPONENT_BITS-1:0] brightness = '0;
	logic                      out_valid;
	logic                      out_stall  = 1'b0;
	logic [COMPONENT_BITS-1:0] red;
	logic [COMPONENT_BITS-1:0] green;
	logic [COMPONENT_BITS-1:0] blue;

	hsv_req_t pending_reqs[$];
	rgb_t     rgb_expected[$];

	int unsigned cycle_count  = 0;
	int unsigned reqs_sent    = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches   = 0;
	int unsigned hues_clamped = 0;

	// driver state
	hsv_req_t    next_req;
	bit          staged   = 1'b0;
	int unsigned gap_left = 0;

	// receiver state
	int unsigned rx_wait   = 0;
	int unsigned hold_left = 0;
	bit          long_done = 1'b0;
	bit          rx_calm   = 1'b0;

	hsv_to_rgb_converter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hexcone conversion in fixed point: clamp hue, chroma = round(V*S/MAXC),
	// split hue into sector and remainder, derive the secondary component,
	// place C / X / 0 by sector and lift every channel by V - C.
	function automatic rgb_t hsv_to_rgb_predict(input logic [HUE_W-1:0] h_in,
			input logic [COMPONENT_BITS-1:0] s_in, input logic [COMPONENT_BITS-1:0] v_in);
		longint unsigned  h, ss, vv, c, frac, x, off, r1, g1, b1;
		logic [SEC_W-1:0] sec;
		rgb_t             res;
		h  = h_in;
		ss = s_in;
		vv = v_in;
		if (h > HUE_FULL)
			h = HUE_FULL;
		c    = (vv * ss + COMP_MAX / 2) / COMP_MAX;
		sec  = SEC_W'(h / SECT);
		frac = h % SECT;
		// even sectors ramp X up, odd sectors ramp it down
		if (!sec[0])
			x = (c * frac + SECT / 2) / SECT;
		else
			x = (c * (SECT - frac) + SECT / 2) / SECT;
		case (sec)
			SEC_RED_YEL: begin r1 = c; g1 = x; b1 = 0; end
			SEC_YEL_GRN: begin r1 = x; g1 = c; b1 = 0; end
			SEC_GRN_CYN: begin r1 = 0; g1 = c; b1 = x; end
			SEC_CYN_BLU: begin r1 = 0; g1 = x; b1 = c; end
			SEC_BLU_MAG: begin r1 = x; g1 = 0; b1 = c; end
			// last sector, and hue at exactly 360 degrees
			default: begin r1 = c; g1 = 0; b1 = x; end
		endcase
		off       = vv - c;
		res.red   = COMPONENT_BITS'(r1 + off);
		res.green = COMPONENT_BITS'(g1 + off);
		res.blue  = COMPONENT_BITS'(b1 + off);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int exp_v, input int got_v);
		if (mismatches < MAX_PRINTED)
			$display("MISMATCH at %0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
		mismatches++;
	endtask

	task automatic add_req(input int h, input int s, input int v, input int unsigned gap);
		hsv_req_t r;
		r.hue   = HUE_W'(h);
		r.sat   = COMPONENT_BITS'(s);
		r.val   = COMPONENT_BITS'(v);
		r.gap   = gap;
		r.drain = 1'b0;
		pending_reqs.push_back(r);
	endtask

	task automatic add_drain();
		hsv_req_t r;
		r       = '{default: '0};
		r.drain = 1'b1;
		pending_reqs.push_back(r);
	endtask

	function automatic int rand_comp();
		case ($urandom_range(0, 9))
			0, 1:    return 0;
			2, 3:    return COMP_MAX;
			4:       return $urandom_range(0, 3);
			default: return $urandom_range(0, COMP_MAX);
		endcase
	endfunction

	// Driver: count the accepted request into the expectation queue, then
	// hold, idle for the drawn gap, or present the next request. in_valid gets
	// exactly one assignment per edge so back-to-back requests keep it high.
	always @(posedge clk) begin : driver
		bit busy;
		bit drive_valid;
		if (arst_n) begin
			busy = in_valid;
			if (in_valid && !in_stall) begin
				rgb_expected.push_back(hsv_to_rgb_predict(hue, saturation, brightness));
				if (hue > HUE_FULL)
					hues_clamped++;
				reqs_sent++;
				busy = 1'b0;
			end
			drive_valid = busy;
			if (!busy) begin
				if (!staged && pending_reqs.size() != 0) begin
					next_req = pending_reqs.pop_front();
					staged   = 1'b1;
					gap_left = next_req.gap;
				end
				if (staged) begin
					if (next_req.drain) begin
						// pause the sender until every outstanding result is back
						if (rgb_expected.size() == 0)
							staged = 1'b0;
					end else if (gap_left != 0) begin
						gap_left--;
					end else begin
						hue         <= next_req.hue;
						saturation  <= next_req.sat;
						brightness  <= next_req.val;
						drive_valid = 1'b1;
						staged      = 1'b0;
					end
				end
			end
			in_valid <= drive_valid;
		end
	end

	// Monitor: check each accepted result against the oldest expectation, then
	// pick the stall for the following cycles. A single long hold-off, counted
	// here, lets the pipeline fill and back up into in_stall.
	always @(posedge clk) begin : monitor
		rgb_t exp_rgb;
		bit   stall_n;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (rgb_expected.size() == 0) begin
					report_mismatch("result with no pending request, red", 0, red);
				end else begin
					exp_rgb = rgb_expected.pop_front();
					if (red !== exp_rgb.red)
						report_mismatch($sformatf("result %0d red", results_seen),
							exp_rgb.red, red);
					if (green !== exp_rgb.green)
						report_mismatch($sformatf("result %0d green", results_seen),
							exp_rgb.green, green);
					if (blue !== exp_rgb.blue)
						report_mismatch($sformatf("result %0d blue", results_seen),
							exp_rgb.blue, blue);
				end
				results_seen++;
				// every 64 results pick afresh between no stalls and random stalls
				if (results_seen % 64 == 0)
					rx_calm = ($urandom_range(0, 2) == 0);
				rx_wait = rx_calm ? 0 : $urandom_range(0, 15);
			end
			if (hold_left != 0) begin
				hold_left--;
				stall_n = 1'b1;
			end else if (!long_done && results_seen >= LONG_HOLD_AT) begin
				long_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				stall_n   = 1'b1;
			end else if (rx_wait != 0) begin
				rx_wait--;
				stall_n = 1'b1;
			end else begin
				stall_n = 1'b0;
			end
			out_stall <= stall_n;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, rgb_expected.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int          mode;
		int          h;
		int unsigned gap;
		// Directed: black, white, every sector start, sector middles with
		// half-way rounding, the last hue below 360, exactly 360, the clamp.
		add_req(0,     255, 255, 0);
		add_req(0,     0,   255, 0);
		add_req(0,     255, 0,   0);
		add_req(0,     0,   0,   3);
		add_req(1,     255, 255, 0);
		add_req(1920,  255, 255, 0);
		add_req(3839,  255, 255, 1);
		add_req(3840,  255, 255, 0);
		add_req(5760,  255, 200, 0);
		add_req(7680,  255, 255, 2);
		add_req(9600,  128, 255, 0);
		add_req(11520, 255, 255, 0);
		add_req(13440, 200, 100, 0);
		add_req(15360, 255, 255, 5);
		add_req(17280, 255, 128, 0);
		add_req(19200, 255, 255, 0);
		add_req(21120, 77,  191, 0);
		add_req(23039, 255, 255, 0);
		add_req(23040, 255, 255, 0);
		add_req(23041, 255, 255, 4);
		add_req(65535, 255, 255, 0);
		add_req(65535, 128, 1,   0);
		add_req(30000, 1,   255, 0);
		add_req(12345, 128, 128, 0);
		add_req(7,     1,   1,   0);
		add_drain();

		// Random blocks: each block picks its own idling style.
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i % BLOCK_REQS == 0)
				mode = $urandom_range(0, 2);
			if (i == RANDOM_REQS / 2)
				add_drain();
			case ($urandom_range(0, 9))
				0:       h = $urandom_range(HUE_FULL + 1, 65535);
				1:       h = $urandom_range(0, 65535);
				2:       h = $urandom_range(0, NUM_SECT) * SECT + $urandom_range(0, 2) - 1;
				default: h = $urandom_range(0, HUE_FULL);
			endcase
			if (h < 0)
				h = 0;
			case (mode)
				0:       gap = 0;
				1:       gap = $urandom_range(0, 15);
				default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 0;
			endcase
			add_req(h, rand_comp(), rand_comp(), gap);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the last request to go in and every result to come back.
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || staged || in_valid || rgb_expected.size() != 0);
		// linger to catch any stray result
		repeat (4 * PIPE_LATENCY) @(negedge clk);
		if (rgb_expected.size() != 0)
			report_mismatch("results still outstanding", 0, rgb_expected.size());

		$display("Sent %0d requests (%0d with clamped hue) and checked %0d results,",
			reqs_sent, hues_clamped, results_seen);
		$display("covering all sectors, random stalls on both sides and a full pipeline.");
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
